// ===== rtl/core/wvd_pkg.sv =====
// shared types and constants for the windowed vote debounce block
// no dependencies; compile first
package wvd_pkg;

   localparam int WORD_W     = 64;
   localparam int DEPTH_W    = 5;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;
   localparam int REG_IDX_W  = 2;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_WINDOW_DEPTH   = 2'd0,
      REG_VOTE_THRESHOLD = 2'd1,
      REG_BYPASS_MASK    = 2'd2,
      REG_INITIAL_OUTPUT = 2'd3
   } wvd_reg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } wvd_state_type;

   // configuration as seen by the datapath, with a restart strobe
   typedef struct packed {
      logic [DEPTH_W-1:0] window_depth;
      logic [DEPTH_W-1:0] vote_threshold;
      logic [WORD_W-1:0]  bypass_mask;
      logic [WORD_W-1:0]  restart_value;
      logic               restart;
   } wvd_cfg_type;

endpackage

// ===== rtl/core/wvd_chan_if.sv =====
// valid/ready channel interfaces for sample and result beats
// depends on wvd_pkg
interface wvd_req_if;
   logic                      valid;
   logic                      ready;
   logic [wvd_pkg::WORD_W-1:0] io_sample;

   modport source (output valid, output io_sample, input ready);
   modport sink   (input valid, input io_sample, output ready);
endinterface

interface wvd_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [wvd_pkg::WORD_W-1:0] filtered_io;

   modport source (output valid, output filtered_io, input ready);
   modport sink   (input valid, input filtered_io, output ready);
endinterface

// ===== rtl/core/windowed_vote_io_debounce_unit.sv =====
// ST_IDLE takes a sample beat, ST_RUN visits each line, ST_FINISH loads the
//   result beat; no new sample until back in ST_IDLE; the shared vote unit
//   visits one line per cycle through the dual-port history column ram
// reset (synchronous, active high): registers to 1, 1, 0, 0, history cleared at
//   once through per-line valid bits, output state zero; no clearing pass
// depends on wvd_pkg, wvd_chan_if, wvd_csr, wvd_vote_unit, wvd_ram
module windowed_vote_io_debounce_unit #(
   parameter int MAX_DEPTH  = 16,
   parameter int LINE_COUNT = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [wvd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [wvd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [wvd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                          csr_pready,
   wvd_req_if.sink                       req_bus,
   wvd_rsp_if.source                     rsp_bus
);

   localparam int PW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int LW = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
   localparam int CW = ($clog2(MAX_DEPTH+1) > 5) ? $clog2(MAX_DEPTH+1) : 5;
   localparam logic [wvd_pkg::WORD_W-1:0] LINE_MASK = (LINE_COUNT >= wvd_pkg::WORD_W) ?
      {wvd_pkg::WORD_W{1'b1}} :
      ((wvd_pkg::WORD_W'(1) << LINE_COUNT) - wvd_pkg::WORD_W'(1));
   localparam logic [LW-1:0] LAST_LINE = LW'(LINE_COUNT - 1);
   localparam logic [PW-1:0] LAST_PTR  = PW'(MAX_DEPTH - 1);

   wvd_pkg::wvd_cfg_type cfg;

   // sequencer and datapath registers
   wvd_pkg::wvd_state_type state_ff, state_in;
   logic [LW-1:0]              line_ff, line_in;
   logic [wvd_pkg::WORD_W-1:0] sample_ff;
   logic [wvd_pkg::WORD_W-1:0] out_ff;
   logic [PW-1:0]              wptr_ff;
   logic [PW-1:0]              newest_ff;
   logic [MAX_DEPTH-1:0]       window_ff, window_in;
   logic [LINE_COUNT-1:0]      col_valid_ff;
   logic                       rsp_valid_ff;
   logic [wvd_pkg::WORD_W-1:0] rsp_data_ff;

   // control decoded from the state
   logic accept;
   logic busy_line;
   logic load_rsp;
   logic ready;

   // effective depth and threshold
   logic [CW-1:0] depth_raw, depth_eff, thr_raw, thr_eff;

   // vote unit and ram hookup
   logic [MAX_DEPTH-1:0] col_rd;
   logic [MAX_DEPTH-1:0] col_wr;
   logic                 toggle;
   logic                 changed;
   logic                 bypass_bit;
   logic [LW-1:0]        rd_addr;

   wvd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // depth zero acts as one, large depth saturates, threshold clamps to depth
   always_comb begin
      depth_raw = CW'(cfg.window_depth);
      thr_raw   = CW'(cfg.vote_threshold);
      if (depth_raw == '0) begin
         depth_eff = CW'(1);
      end else if (depth_raw > CW'(MAX_DEPTH)) begin
         depth_eff = CW'(MAX_DEPTH);
      end else begin
         depth_eff = depth_raw;
      end
      thr_eff = (thr_raw > depth_eff) ? depth_eff : thr_raw;
   end

   // window of the depth newest ring slots, newest being the current write slot
   always_comb begin
      for (int j = 0; j < MAX_DEPTH; j++) begin
         logic [CW-1:0] slot_dist;
         if (CW'(wptr_ff) >= CW'(j)) begin
            slot_dist = CW'(wptr_ff) - CW'(j);
         end else begin
            slot_dist = CW'(MAX_DEPTH) - (CW'(j) - CW'(wptr_ff));
         end
         window_in[j] = (slot_dist < depth_eff);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wvd_pkg::ST_IDLE: begin
            if (req_bus.valid) begin
               state_in = wvd_pkg::ST_RUN;
            end
         end
         wvd_pkg::ST_RUN: begin
            if (line_ff == LAST_LINE) begin
               state_in = wvd_pkg::ST_FINISH;
            end
         end
         wvd_pkg::ST_FINISH: begin
            // wait here while the previous result beat is still unclaimed
            if (!rsp_valid_ff || rsp_bus.ready) begin
               state_in = wvd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wvd_pkg::ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      ready     = 1'b0;
      busy_line = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         wvd_pkg::ST_IDLE:   ready     = 1'b1;
         wvd_pkg::ST_RUN:    busy_line = 1'b1;
         wvd_pkg::ST_FINISH: load_rsp  = !rsp_valid_ff || rsp_bus.ready;
         default:            ready     = 1'b0;
      endcase
   end

   assign req_bus.ready = ready;
   assign accept        = ready && req_bus.valid;

   // per-line decision inputs; bypassed lines never count as changed
   assign bypass_bit = cfg.bypass_mask[line_ff];
   assign changed    = (sample_ff[line_ff] ^ out_ff[line_ff]) && !bypass_bit;

   // prefetch line 0 while idle, then the following line during each visit
   always_comb begin
      if (busy_line && (line_ff != LAST_LINE)) begin
         rd_addr = line_ff + LW'(1);
      end else begin
         rd_addr = '0;
      end
   end

   assign line_in = accept ? '0 : ((busy_line && (line_ff != LAST_LINE)) ?
                                   line_ff + LW'(1) : line_ff);

   wvd_vote_unit #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_vote (
      .col_in    (col_rd),
      .col_ok    (col_valid_ff[line_ff]),
      .newest    (newest_ff),
      .window    (window_ff),
      .changed   (changed),
      .threshold (thr_eff),
      .col_out   (col_wr),
      .toggle    (toggle)
   );

   // one column of ring history per line: bit k is ring slot k
   wvd_ram #(
      .WIDTH (MAX_DEPTH),
      .DEPTH (LINE_COUNT)
   ) u_hist (
      .clock   (clock),
      .wr_en   (busy_line),
      .wr_addr (line_ff),
      .wr_data (col_wr),
      .rd_addr (rd_addr),
      .rd_data (col_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wvd_pkg::ST_IDLE;
         line_ff      <= '0;
         wptr_ff      <= '0;
         col_valid_ff <= '0;
         out_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         line_ff  <= line_in;
         if (cfg.restart) begin
            // restart: history forgotten, pointer home, output reloaded
            wptr_ff      <= '0;
            col_valid_ff <= '0;
            out_ff       <= cfg.restart_value & LINE_MASK;
         end else begin
            if (accept) begin
               wptr_ff <= (wptr_ff == LAST_PTR) ? '0 : wptr_ff + PW'(1);
            end
            if (busy_line) begin
               col_valid_ff[line_ff] <= 1'b1;
               out_ff[line_ff]       <= bypass_bit ? sample_ff[line_ff] :
                                        (out_ff[line_ff] ^ toggle);
            end
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= req_bus.io_sample & LINE_MASK;
         newest_ff <= wptr_ff;
         window_ff <= window_in;
      end
      if (load_rsp) begin
         rsp_data_ff <= out_ff & LINE_MASK;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.filtered_io = rsp_data_ff;

endmodule

// ===== rtl/core/wvd_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module wvd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/wvd_csr.sv =====
// apb-style register file for depth, threshold, bypass and initial value
// depends on wvd_pkg
module wvd_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [wvd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [wvd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [wvd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                          csr_pready,
   output wvd_pkg::wvd_cfg_type          cfg
);

   logic [wvd_pkg::DEPTH_W-1:0] depth_ff, depth_in;
   logic [wvd_pkg::DEPTH_W-1:0] thr_ff, thr_in;
   logic [wvd_pkg::WORD_W-1:0]  bypass_ff, bypass_in;
   logic [wvd_pkg::WORD_W-1:0]  init_ff, init_in;
   logic                        wr_stb;
   logic                        restart;
   wvd_pkg::wvd_reg_type        reg_idx;

   assign csr_pready = 1'b1;
   assign wr_stb     = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = wvd_pkg::wvd_reg_type'(csr_paddr[wvd_pkg::CSR_ADDR_W-1 -: 2]);

   always_comb begin
      depth_in = depth_ff;
      thr_in   = thr_ff;
      bypass_in = bypass_ff;
      init_in  = init_ff;
      restart  = 1'b0;
      if (wr_stb) begin
         case (reg_idx)
            wvd_pkg::REG_WINDOW_DEPTH: begin
               depth_in = csr_pwdata[wvd_pkg::DEPTH_W-1:0];
               restart  = 1'b1;
            end
            wvd_pkg::REG_VOTE_THRESHOLD: begin
               thr_in  = csr_pwdata[wvd_pkg::DEPTH_W-1:0];
               restart = 1'b1;
            end
            wvd_pkg::REG_BYPASS_MASK: begin
               bypass_in = csr_pwdata;
            end
            wvd_pkg::REG_INITIAL_OUTPUT: begin
               init_in = csr_pwdata;
               restart = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff  <= wvd_pkg::DEPTH_W'(1);
         thr_ff    <= wvd_pkg::DEPTH_W'(1);
         bypass_ff <= '0;
         init_ff   <= '0;
      end else begin
         depth_ff  <= depth_in;
         thr_ff    <= thr_in;
         bypass_ff <= bypass_in;
         init_ff   <= init_in;
      end
   end

   always_comb begin
      case (reg_idx)
         wvd_pkg::REG_WINDOW_DEPTH:   csr_prdata = wvd_pkg::CSR_DATA_W'(depth_ff);
         wvd_pkg::REG_VOTE_THRESHOLD: csr_prdata = wvd_pkg::CSR_DATA_W'(thr_ff);
         wvd_pkg::REG_BYPASS_MASK:    csr_prdata = bypass_ff;
         wvd_pkg::REG_INITIAL_OUTPUT: csr_prdata = init_ff;
         default:                     csr_prdata = '0;
      endcase
   end

   // restart value follows a write landing this same cycle
   always_comb begin
      cfg.window_depth   = depth_ff;
      cfg.vote_threshold = thr_ff;
      cfg.bypass_mask    = bypass_ff;
      cfg.restart_value  = init_in;
      cfg.restart        = restart;
   end

endmodule

// ===== rtl/core/wvd_vote_unit.sv =====
// shared per-line vote unit: inserts the newest change bit, counts the window
// and inverts the window bits on acceptance; no package dependency
module wvd_vote_unit #(
   parameter int MAX_DEPTH = 16
) (
   input  logic [MAX_DEPTH-1:0] col_in,
   input  logic                 col_ok,
   input  logic [(MAX_DEPTH > 1 ? $clog2(MAX_DEPTH) : 1)-1:0] newest,
   input  logic [MAX_DEPTH-1:0] window,
   input  logic                 changed,
   input  logic [(($clog2(MAX_DEPTH+1) > 5) ? $clog2(MAX_DEPTH+1) : 5)-1:0] threshold,
   output logic [MAX_DEPTH-1:0] col_out,
   output logic                 toggle
);

   localparam int CW = ($clog2(MAX_DEPTH+1) > 5) ? $clog2(MAX_DEPTH+1) : 5;

   logic [MAX_DEPTH-1:0] col_new;
   logic [MAX_DEPTH-1:0] hits;
   logic [CW-1:0]        count;

   always_comb begin
      col_new         = col_ok ? col_in : '0;
      col_new[newest] = changed;
      hits            = col_new & window;
      count           = '0;
      for (int j = 0; j < MAX_DEPTH; j++) begin
         count = count + CW'(hits[j]);
      end
      toggle  = changed && (count >= threshold);
      col_out = toggle ? (col_new ^ window) : col_new;
   end

endmodule

// ===== rtl/core/wvd_checker.sv =====
// port-level checks for the debounce block, bound to the top level
// depends on wvd_pkg
module wvd_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [wvd_pkg::WORD_W-1:0]   rsp_data
);

   // no result beat offered right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a sample beat keeps the block from taking another while its line pass runs
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (!req_ready ##1 !req_ready))
      else $error("sample taken while a line pass is running");

   // a stalled result beat holds its payload
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result beat changed");

endmodule

bind windowed_vote_io_debounce_unit wvd_checker u_wvd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_data  (rsp_bus.filtered_io)
);
